// ===== hw/rtl/akd_pkg.sv =====
// ----------------------------------------------------------------------------
// akd_pkg
// Shared constants, types and reset values for the ladder keypad decoder.
// ----------------------------------------------------------------------------
package akd_pkg;

    // Converter and scaling
    localparam int ADC_BITS      = 10;
    localparam int ADC_MAX       = (1 << ADC_BITS) - 1;   // divisor is 2^k - 1
    localparam int FULL_SCALE_MV = 1800;
    localparam int WINDOW_MV     = 100;
    localparam int NUM_BUTTONS   = 8;

    // Widths
    localparam int SAMPLE_W   = ADC_BITS;
    localparam int MV_W       = $clog2(FULL_SCALE_MV + 1);
    localparam int PROD_W     = SAMPLE_W + MV_W;
    localparam int QEST_W     = PROD_W - ADC_BITS;
    localparam int REM_W      = QEST_W + 2;
    localparam int LEVEL_W    = 11;
    localparam int CMP_W      = LEVEL_W + 1;
    localparam int BTN_W      = 3;
    localparam int NUM_LEVELS = 8;

    // Register file / APB
    localparam int REG_IDX_W = $clog2(NUM_LEVELS);
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    // Queue between classifier and event logic
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int CRED_W  = QCNT_W + 1;

    typedef logic [LEVEL_W-1:0]        level_t;
    typedef level_t [NUM_LEVELS-1:0]   level_arr_t;

    localparam level_arr_t LEVEL_RESET = {
        LEVEL_W'(600),  LEVEL_W'(400),  LEVEL_W'(1800), LEVEL_W'(1400),
        LEVEL_W'(1200), LEVEL_W'(1000), LEVEL_W'(1600), LEVEL_W'(800)
    };

    // Classified sample: which button window (if any) the sample fell in
    typedef struct packed {
        logic             hit;
        logic [BTN_W-1:0] idx;
    } class_t;

    // Queue occupancy seen by both sides
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } q_status_t;

endpackage

// ===== hw/rtl/akd_front.sv =====
// ----------------------------------------------------------------------------
// akd_front
// Sample intake: scale to millivolts, window compare, priority pick.
// ----------------------------------------------------------------------------
module akd_front
    import akd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SAMPLE_W-1:0] adc_sample,
    input  logic                in_valid,
    output logic                in_ready,
    input  level_arr_t          levels,
    input  q_status_t           q_status,
    output logic                push,
    output class_t              push_data
);

    logic              v1_reg, v1_next;
    logic              v2_reg, v2_next;
    logic [PROD_W-1:0] prod_reg;
    logic [MV_W-1:0]   mv_reg;
    logic [MV_W-1:0]   mv_next;
    logic [QEST_W-1:0] q_est;
    logic [REM_W-1:0]  rem;
    logic [CRED_W-1:0] credit;
    logic              accept;

    // Items in flight plus queued must fit the queue
    assign credit   = CRED_W'(q_status.count) + CRED_W'(v1_reg) + CRED_W'(v2_reg);
    assign in_ready = (credit < CRED_W'(QDEPTH));
    assign accept   = in_valid & in_ready;

    assign v1_next = accept;
    assign v2_next = v1_reg;

    // Divide by 2^k - 1: estimate by shift, remainder = low bits + estimate,
    // then correct by up to two.
    always_comb
    begin
        q_est = prod_reg[PROD_W-1:ADC_BITS];
        rem   = REM_W'(prod_reg[ADC_BITS-1:0]) + REM_W'(q_est);
        if (rem >= REM_W'(2 * ADC_MAX))
            mv_next = MV_W'(q_est + QEST_W'(2));
        else if (rem >= REM_W'(ADC_MAX))
            mv_next = MV_W'(q_est + QEST_W'(1));
        else
            mv_next = MV_W'(q_est);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            prod_reg <= PROD_W'(adc_sample) * PROD_W'(FULL_SCALE_MV);
        if (v1_reg)
            mv_reg <= mv_next;
    end

    // Open window (level - W, level + W); lowest index wins
    always_comb
    begin
        push_data = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--)
        begin
            if ((CMP_W'(mv_reg) + CMP_W'(WINDOW_MV) > CMP_W'(levels[i])) &&
                (CMP_W'(mv_reg) < CMP_W'(levels[i]) + CMP_W'(WINDOW_MV)))
            begin
                push_data.hit = 1'b1;
                push_data.idx = BTN_W'(i);
            end
        end
    end

    assign push = v2_reg;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit <= CRED_W'(QDEPTH))
        else $error("front: items in flight exceed queue room");

endmodule

// ===== hw/rtl/akd_queue.sv =====
// ----------------------------------------------------------------------------
// akd_queue
// Small FIFO of classified samples between intake and event logic.
// ----------------------------------------------------------------------------
module akd_queue
    import akd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  class_t    push_data,
    input  logic      pop,
    output class_t    pop_data,
    output q_status_t q_status
);

    class_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data       = mem_reg[rd_ptr_reg];
    assign q_status.count = count_reg;
    assign q_status.empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCNT_W'(QDEPTH)))
        else $error("queue: push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue: pop while empty");

endmodule

// ===== hw/rtl/akd_back.sv =====
// ----------------------------------------------------------------------------
// akd_back
// Held-button tracking and press/release event output register.
// ----------------------------------------------------------------------------
module akd_back
    import akd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  q_status_t        q_status,
    input  class_t           pop_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [BTN_W-1:0] button,
    output logic             is_press
);

    logic             held_valid_reg, held_valid_next;
    logic [BTN_W-1:0] held_index_reg, held_index_next;
    logic             out_valid_reg, out_valid_next;
    logic [BTN_W-1:0] button_reg, button_next;
    logic             is_press_reg, is_press_next;
    logic             emit;

    assign pop = !q_status.empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_index_next = held_index_reg;
        button_next     = button_reg;
        is_press_next   = is_press_reg;
        emit            = 1'b0;
        if (pop)
        begin
            if (pop_data.hit && !held_valid_reg)
            begin
                emit            = 1'b1;
                button_next     = pop_data.idx;
                is_press_next   = 1'b1;
                held_valid_next = 1'b1;
                held_index_next = pop_data.idx;
            end
            else if (held_valid_reg &&
                     !(pop_data.hit && (pop_data.idx == held_index_reg)))
            begin
                // other button or nothing: release, go idle
                emit            = 1'b1;
                button_next     = held_index_reg;
                is_press_next   = 1'b0;
                held_valid_next = 1'b0;
            end
        end
        out_valid_next = pop ? emit : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_index_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_index_reg <= held_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        button_reg   <= button_next;
        is_press_reg <= is_press_next;
    end

    assign out_valid = out_valid_reg;
    assign button    = button_reg;
    assign is_press  = is_press_reg;

    a_press_sets_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_data.hit && !held_valid_reg) |=>
            (held_valid_reg && out_valid_reg && is_press_reg &&
             (held_index_reg == button_reg)))
        else $error("back: press did not latch held button");

    a_release_of_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && held_valid_reg &&
         !(pop_data.hit && (pop_data.idx == held_index_reg))) |=>
            (out_valid_reg && !is_press_reg && !held_valid_reg &&
             (button_reg == $past(held_index_reg))))
        else $error("back: release does not name held button");

endmodule

// ===== hw/rtl/adc_ladder_keypad_decoder_top.sv =====
// ----------------------------------------------------------------------------
// adc_ladder_keypad_decoder_top
// Resistor-ladder keypad decoder: ADC sample in, press/release events out.
//
//   Channel  Handshake            Payload                 Dir
//   -------  -------------------  ----------------------  ---
//   config   psel/penable/pready  paddr, pwdata, prdata   in
//   sample   in_valid/in_ready    adc_sample[9:0]         in
//   event    out_valid/out_ready  button[2:0], is_press   out
//
// One sample transfer per clock sustained while out_ready keeps up. The
// product is taken on the transfer edge; the sample then passes through
// the millivolt register, the queue and the event register. The event
// side drains the queue one entry a cycle unless an event waits on
// out_ready; the queue then fills and in_ready drops once the queue plus
// the two intake stages would overflow. Reset clears handshake state, the
// held button and reloads the level registers; no clearing pass.
// ----------------------------------------------------------------------------
module adc_ladder_keypad_decoder_top
    import akd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // APB-style config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // sample channel
    input  logic [SAMPLE_W-1:0] adc_sample,
    input  logic                in_valid,
    output logic                in_ready,
    // event channel
    output logic [BTN_W-1:0]    button,
    output logic                is_press,
    output logic                out_valid,
    input  logic                out_ready
);

    level_arr_t           levels_reg, levels_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    q_status_t q_status;
    logic      push;
    class_t    push_data;
    logic      pop;
    class_t    pop_data;

    // Config registers: level i at byte address 4*i, low 11 bits kept.
    // Written only while the decoder is idle, a rule on the user that the
    // block does not enforce; so no hazard with the classifier reading them.
    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = PDATA_W'(levels_reg[reg_idx]);

    always_comb
    begin
        levels_next = levels_reg;
        if (cfg_wr)
            levels_next[reg_idx] = pwdata[LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            levels_reg <= LEVEL_RESET;
        else
            levels_reg <= levels_next;
    end

    // Intake: scale and classify, push into the queue
    akd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adc_sample (adc_sample),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .levels     (levels_reg),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    // Decouples intake from event-side backpressure
    akd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .pop_data   (pop_data),
        .q_status   (q_status)
    );

    // Held-button state and event register
    akd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .button     (button),
        .is_press   (is_press)
    );

endmodule
